// File: design/shp_pkg.sv
package shp_pkg;

    // sizing
    localparam int unsigned MAX_PACKET_BYTES_DEF = 65536;
    localparam int unsigned BITPOS_W   = 20;
    localparam int unsigned SIZE_W     = 17;
    localparam int unsigned TS_W       = 64;
    localparam int unsigned RES_W      = 32;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned US_PER_SEC = 1000000;
    localparam int unsigned MUL_STEPS  = 20;
    localparam int unsigned PROD_W     = TS_W + MUL_STEPS;
    localparam int unsigned APB_DW     = 32;
    localparam int unsigned APB_AW     = 5;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // result word
    typedef struct packed {
        logic              au_start;
        logic              au_end;
        logic [TS_W-1:0]   dts_us;
        logic [TS_W-1:0]   pts_us;
        logic [SIZE_W-1:0] header_bytes;
    } out_word_t;

    // configuration registers
    typedef struct packed {
        logic [7:0]       sl_flags;
        logic [RES_W-1:0] timestamp_resolution;
        logic [LEN_W-1:0] timestamp_length;
        logic [LEN_W-1:0] ocr_length;
        logic [LEN_W-1:0] au_length_bits;
        logic [LEN_W-1:0] bitrate_length;
        logic [13:0]      sequence_field_lengths;
    } cfg_t;

    // register indexes
    typedef enum logic [2:0] {
        REG_SL_FLAGS,
        REG_TS_RES,
        REG_TS_LEN,
        REG_OCR_LEN,
        REG_AU_LEN,
        REG_BR_LEN,
        REG_SEQ_LEN
    } reg_idx_t;

    // header fields in stream order
    typedef enum logic [4:0] {
        PH_AU_START,
        PH_AU_END,
        PH_OCR_FLAG,
        PH_IDLE_FLAG,
        PH_PAD_FLAG,
        PH_PADVAL,
        PH_SEQ,
        PH_DEG_FLAG,
        PH_DEG,
        PH_OCR,
        PH_RAP,
        PH_AU_SEQ,
        PH_DTS_FLAG,
        PH_CTS_FLAG,
        PH_BR_FLAG,
        PH_DTS,
        PH_CTS,
        PH_AU_LEN,
        PH_BR,
        PH_DONE
    } phase_t;

    // parser mode
    typedef enum logic [1:0] {
        PM_IDLE,
        PM_BYTE,
        PM_DRAIN,
        PM_DONE
    } pmode_t;

    // converter state
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV,
        DV_DONE
    } div_state_t;

    // top level sequencer
    typedef enum logic [2:0] {
        T_PARSE,
        T_DTS,
        T_DTS_WAIT,
        T_CTS,
        T_CTS_WAIT,
        T_OUT
    } top_state_t;

    // parsed packet summary
    typedef struct packed {
        logic [7:0]        flags;
        logic [TS_W-1:0]   raw_dts;
        logic [TS_W-1:0]   raw_cts;
        logic [SIZE_W-1:0] header_bytes;
    } pkt_stat_t;

endpackage

// File: design/shp_parser.sv
module shp_parser #(
    parameter int unsigned MAX_PACKET_BYTES = shp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  shp_pkg::cfg_t      cfg,
    input  logic               load,
    input  shp_pkg::in_word_t  word,
    output logic               in_ready,
    output logic               pkt_done,
    input  logic               pkt_clear,
    output shp_pkg::pkt_stat_t stat
);
    import shp_pkg::*;

    localparam int unsigned BC_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned CL_W = BITPOS_W - 2;
    localparam int unsigned CW   = (BC_W > CL_W) ? BC_W : CL_W;

    pmode_t              mode_reg, mode_next;
    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    logic [TS_W-1:0]     acc_reg, acc_next;
    logic [7:0]          flags_reg, flags_next;
    logic [2:0]          padval_reg, padval_next;
    logic [BITPOS_W-1:0] bitpos_reg, bitpos_next;
    logic [BC_W-1:0]     bc_reg, bc_next;
    logic [TS_W-1:0]     dts_reg, dts_next;
    logic [TS_W-1:0]     cts_reg, cts_next;
    logic [7:0]          sh_reg, sh_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                last_reg, last_next;

    logic [7:0]       flags_eff;
    logic [LEN_W-1:0] n;
    logic             skip_opt;
    logic             working;
    logic             settle_act;
    logic             at_done;
    logic             bit_in;
    logic [TS_W-1:0]  acc_new;
    logic             b;
    logic             byte_end;
    logic [BITPOS_W:0] bp7;
    logic [CW-1:0]    ceil_b;
    logic [CW-1:0]    bc_x;
    logic [CW-1:0]    size_c;

    // flags with the au default applied at the padding value field
    always_comb begin
        flags_eff = flags_reg;
        if (phase_reg == PH_PADVAL && flags_reg[1:0] == 2'b00) begin
            flags_eff[1:0] = 2'b11;
        end
    end

    // length of the current field
    always_comb begin
        skip_opt = flags_eff[3] | (flags_eff[4] & (padval_reg != 3'd0));
        n = '0;
        unique case (phase_reg)
            PH_AU_START:  n = LEN_W'(cfg.sl_flags[7]);
            PH_AU_END:    n = LEN_W'(cfg.sl_flags[6]);
            PH_OCR_FLAG:  n = LEN_W'(cfg.ocr_length != '0);
            PH_IDLE_FLAG: n = LEN_W'(cfg.sl_flags[1]);
            PH_PAD_FLAG:  n = LEN_W'(cfg.sl_flags[3]);
            PH_PADVAL:    n = flags_eff[4] ? LEN_W'(3) : '0;
            PH_SEQ:       n = LEN_W'(cfg.sequence_field_lengths[4:0]);
            PH_DEG_FLAG:  n = LEN_W'(cfg.sequence_field_lengths[13:10] != 4'd0);
            PH_DEG:       n = LEN_W'(cfg.sequence_field_lengths[13:10]);
            PH_OCR:       n = flags_eff[2] ? cfg.ocr_length : '0;
            PH_RAP:       n = LEN_W'(cfg.sl_flags[5]);
            PH_AU_SEQ:    n = LEN_W'(cfg.sequence_field_lengths[9:5]);
            PH_DTS_FLAG:  n = LEN_W'(cfg.sl_flags[2]);
            PH_CTS_FLAG:  n = LEN_W'(cfg.sl_flags[2]);
            PH_BR_FLAG:   n = LEN_W'(cfg.bitrate_length != '0);
            PH_DTS:       n = flags_eff[5] ? cfg.timestamp_length : '0;
            PH_CTS:       n = flags_eff[6] ? cfg.timestamp_length : '0;
            PH_AU_LEN:    n = cfg.au_length_bits;
            PH_BR:        n = flags_eff[7] ? cfg.bitrate_length : '0;
            default:      n = '0;
        endcase
        if (phase_reg >= PH_SEQ && skip_opt) begin
            n = '0;
        end
        if (phase_reg >= PH_RAP && !flags_eff[0]) begin
            n = '0;
        end
    end

    assign working    = (mode_reg == PM_BYTE) || (mode_reg == PM_DRAIN);
    assign at_done    = (phase_reg == PH_DONE);
    assign settle_act = (left_reg == '0) && !at_done;
    assign bit_in     = (mode_reg == PM_BYTE) ? sh_reg[7] : 1'b0;
    assign acc_new    = {acc_reg[TS_W-2:0], bit_in};
    assign b          = acc_new[0];

    // one header bit or one settle step per cycle while a byte is shifted or the fields drain
    always_comb begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        flags_next  = flags_reg;
        padval_next = padval_reg;
        bitpos_next = bitpos_reg;
        bc_next     = bc_reg;
        dts_next    = dts_reg;
        cts_next    = cts_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        byte_end    = 1'b0;
        if (load) begin
            sh_next   = word.data_byte;
            last_next = word.last_byte;
            cnt_next  = 4'd8;
            mode_next = PM_BYTE;
            if (bc_reg != BC_W'(MAX_PACKET_BYTES)) begin
                bc_next = bc_reg + BC_W'(1);
            end
        end else if (working) begin
            if (settle_act) begin
                flags_next = flags_eff;
                if (n != '0) begin
                    left_next = n;
                    acc_next  = '0;
                end else begin
                    phase_next = phase_t'(5'(phase_reg) + 5'd1);
                end
            end else if (!at_done) begin
                acc_next  = acc_new;
                left_next = left_reg - LEN_W'(1);
                if (mode_reg == PM_BYTE) begin
                    bitpos_next = bitpos_reg + BITPOS_W'(1);
                    sh_next     = {sh_reg[6:0], 1'b0};
                    cnt_next    = cnt_reg - 4'd1;
                    byte_end    = (cnt_reg == 4'd1);
                end
                if (left_reg == LEN_W'(1)) begin
                    phase_next = phase_t'(5'(phase_reg) + 5'd1);
                    case (phase_reg)
                        PH_AU_START:  flags_next[0] = flags_reg[0] | b;
                        PH_AU_END:    flags_next[1] = flags_reg[1] | b;
                        PH_OCR_FLAG:  flags_next[2] = flags_reg[2] | b;
                        PH_IDLE_FLAG: flags_next[3] = flags_reg[3] | b;
                        PH_PAD_FLAG:  flags_next[4] = flags_reg[4] | b;
                        PH_PADVAL:    padval_next   = acc_new[2:0];
                        PH_DEG_FLAG: begin
                            if (!b) begin
                                phase_next = phase_t'(5'(phase_reg) + 5'd2);
                            end
                        end
                        PH_DTS_FLAG:  flags_next[5] = flags_reg[5] | b;
                        PH_CTS_FLAG:  flags_next[6] = flags_reg[6] | b;
                        PH_BR_FLAG:   flags_next[7] = flags_reg[7] | b;
                        PH_DTS:       dts_next      = acc_new;
                        PH_CTS:       cts_next      = acc_new;
                        default:      ;
                    endcase
                end
            end
            // leftover bits of a byte after the header are dropped
            if (mode_reg == PM_BYTE && (byte_end || at_done)) begin
                if (!last_reg) begin
                    mode_next = PM_IDLE;
                end else if (at_done) begin
                    mode_next = PM_DONE;
                end else begin
                    mode_next = PM_DRAIN;
                end
            end else if (mode_reg == PM_DRAIN && at_done) begin
                mode_next = PM_DONE;
            end
        end else if (mode_reg == PM_DONE && pkt_clear) begin
            mode_next   = PM_IDLE;
            phase_next  = PH_AU_START;
            left_next   = '0;
            acc_next    = '0;
            flags_next  = '0;
            padval_next = '0;
            bitpos_next = '0;
            bc_next     = '0;
            dts_next    = '0;
            cts_next    = '0;
        end
    end

    // header size
    always_comb begin
        bp7    = {1'b0, bitpos_reg} + (BITPOS_W + 1)'(7);
        ceil_b = CW'(bp7[BITPOS_W:3]);
        bc_x   = CW'(bc_reg);
        if (flags_reg[4] && padval_reg == 3'd0) begin
            size_c = bc_x;
        end else if (ceil_b > bc_x) begin
            size_c = bc_x;
        end else begin
            size_c = ceil_b;
        end
    end

    assign in_ready          = (mode_reg == PM_IDLE);
    assign pkt_done          = (mode_reg == PM_DONE);
    assign stat.flags        = flags_reg;
    assign stat.raw_dts      = dts_reg;
    assign stat.raw_cts      = cts_reg;
    assign stat.header_bytes = size_c[SIZE_W-1:0];

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= PM_IDLE;
            phase_reg  <= PH_AU_START;
            left_reg   <= '0;
            acc_reg    <= '0;
            flags_reg  <= '0;
            padval_reg <= '0;
            bitpos_reg <= '0;
            bc_reg     <= '0;
            dts_reg    <= '0;
            cts_reg    <= '0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            flags_reg  <= flags_next;
            padval_reg <= padval_next;
            bitpos_reg <= bitpos_next;
            bc_reg     <= bc_next;
            dts_reg    <= dts_next;
            cts_reg    <= cts_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
        end
        sh_reg <= sh_next;
    end

endmodule

// File: design/shp_divider.sv
module shp_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [shp_pkg::TS_W-1:0]  ticks,
    input  logic [shp_pkg::RES_W-1:0] res,
    output logic                      done,
    output logic [shp_pkg::TS_W-1:0]  us
);
    import shp_pkg::*;

    localparam int unsigned CNT_W = $clog2(PROD_W);
    localparam int unsigned MS_IW = $clog2(MUL_STEPS);
    localparam logic [MUL_STEPS-1:0] K = MUL_STEPS'(US_PER_SEC);

    div_state_t        st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [RES_W-1:0]  rem_reg, rem_next;
    logic [TS_W-1:0]   q_reg, q_next;
    logic              ovf_reg, ovf_next;
    logic [TS_W-1:0]   t_reg, t_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic [RES_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, prod_reg[PROD_W-1]};
    assign ge     = rem_sh >= {1'b0, res_reg};

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            DV_IDLE: if (start) st_next = DV_MUL;
            DV_MUL:  if (cnt_reg == '0) st_next = DV_DIV;
            DV_DIV:  if (cnt_reg == '0) st_next = DV_DONE;
            DV_DONE: st_next = DV_IDLE;
            default: st_next = DV_IDLE;
        endcase
    end

    // shift-add multiply by one million, then restoring division
    always_comb begin
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        t_next    = t_reg;
        res_next  = res_reg;
        unique case (st_reg)
            DV_IDLE: begin
                if (start) begin
                    t_next    = ticks;
                    res_next  = res;
                    prod_next = '0;
                    cnt_next  = CNT_W'(MUL_STEPS - 1);
                end
            end
            DV_MUL: begin
                prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                          + (K[cnt_reg[MS_IW-1:0]] ? PROD_W'(t_reg) : '0);
                if (cnt_reg == '0) begin
                    cnt_next = CNT_W'(PROD_W - 1);
                    rem_next = '0;
                    q_next   = '0;
                    ovf_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            DV_DIV: begin
                rem_next  = ge ? RES_W'(rem_sh - {1'b0, res_reg}) : rem_sh[RES_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                q_next    = {q_reg[TS_W-2:0], ge};
                ovf_next  = ovf_reg | q_reg[TS_W-1];
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            default: ;
        endcase
    end

    // result: saturate, else add one unless already all ones
    always_comb begin
        done = (st_reg == DV_DONE);
        if (ovf_reg || (&q_reg)) begin
            us = '1;
        end else begin
            us = q_reg + TS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= DV_IDLE;
        end else begin
            st_reg <= st_next;
        end
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        t_reg    <= t_next;
        res_reg  <= res_next;
    end

endmodule

// File: design/sl_packet_header_parser.sv
// channel  | handshake            | word
// s_       | s_valid / s_ready    | in_word_t: data_byte, last_byte
// m_       | m_valid / m_ready    | out_word_t: au_start, au_end, dts_us, pts_us, header_bytes
// apb      | psel/penable/pready  | seven config registers at 4*index
// the bit-serial parser shifts in a byte after accepting it, one header bit at a time, and
// starts or skips each field in turn; after the last byte the open fields drain with
// zeros, then each present timestamp with a nonzero resolution passes through the shared
// shift-add multiply and restoring divider
// synchronous active-low reset returns the registers to defaults and clears the packet
// a stalled result holds in the output register while the next packet is parsed
module sl_packet_header_parser #(
    parameter int unsigned MAX_PACKET_BYTES = shp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  shp_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output shp_pkg::out_word_t         m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [shp_pkg::APB_AW-1:0] paddr,
    input  logic [shp_pkg::APB_DW-1:0] pwdata,
    output logic [shp_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import shp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    top_state_t st_reg, st_next;
    logic [TS_W-1:0] dts_reg, dts_next;
    logic [TS_W-1:0] pts_reg, pts_next;
    out_word_t  out_reg, out_next;
    logic       mv_reg, mv_next;

    logic       load;
    logic       pkt_done;
    logic       pkt_clear;
    pkt_stat_t  stat;
    logic       div_start;
    logic       div_done;
    logic [TS_W-1:0] div_ticks;
    logic [TS_W-1:0] div_us;
    logic       wr;
    reg_idx_t   idx;
    logic       out_free;
    logic       need_dts;
    logic       need_cts;

    assign pready   = 1'b1;
    assign wr       = psel & penable & pwrite;
    assign idx      = reg_idx_t'(paddr[APB_AW-1:2]);
    assign load     = s_valid & s_ready;
    assign out_free = !mv_reg || m_ready;
    assign need_dts = stat.flags[5] && (cfg_reg.timestamp_resolution != '0);
    assign need_cts = stat.flags[6] && (cfg_reg.timestamp_resolution != '0);

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            unique case (idx)
                REG_SL_FLAGS: cfg_next.sl_flags             = pwdata[7:0];
                REG_TS_RES:   cfg_next.timestamp_resolution = pwdata[RES_W-1:0];
                REG_TS_LEN:   cfg_next.timestamp_length     = pwdata[LEN_W-1:0];
                REG_OCR_LEN:  cfg_next.ocr_length           = pwdata[LEN_W-1:0];
                REG_AU_LEN:   cfg_next.au_length_bits       = pwdata[LEN_W-1:0];
                REG_BR_LEN:   cfg_next.bitrate_length       = pwdata[LEN_W-1:0];
                REG_SEQ_LEN:  cfg_next.sequence_field_lengths = pwdata[13:0];
                default:      ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (idx)
            REG_SL_FLAGS: prdata = APB_DW'(cfg_reg.sl_flags);
            REG_TS_RES:   prdata = APB_DW'(cfg_reg.timestamp_resolution);
            REG_TS_LEN:   prdata = APB_DW'(cfg_reg.timestamp_length);
            REG_OCR_LEN:  prdata = APB_DW'(cfg_reg.ocr_length);
            REG_AU_LEN:   prdata = APB_DW'(cfg_reg.au_length_bits);
            REG_BR_LEN:   prdata = APB_DW'(cfg_reg.bitrate_length);
            REG_SEQ_LEN:  prdata = APB_DW'(cfg_reg.sequence_field_lengths);
            default:      prdata = '0;
        endcase
    end

    // sequencer next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            T_PARSE:    if (pkt_done) st_next = T_DTS;
            T_DTS:      st_next = need_dts ? T_DTS_WAIT : T_CTS;
            T_DTS_WAIT: if (div_done) st_next = T_CTS;
            T_CTS:      st_next = need_cts ? T_CTS_WAIT : T_OUT;
            T_CTS_WAIT: if (div_done) st_next = T_OUT;
            T_OUT:      if (out_free) st_next = T_PARSE;
            default:    st_next = T_PARSE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        div_start = 1'b0;
        div_ticks = stat.raw_dts;
        pkt_clear = 1'b0;
        dts_next  = dts_reg;
        pts_next  = pts_reg;
        out_next  = out_reg;
        mv_next   = mv_reg & ~m_ready;
        unique case (st_reg)
            T_DTS: begin
                div_start = need_dts;
                dts_next  = '0;
            end
            T_DTS_WAIT: if (div_done) dts_next = div_us;
            T_CTS: begin
                div_start = need_cts;
                div_ticks = stat.raw_cts;
                pts_next  = '0;
            end
            T_CTS_WAIT: if (div_done) pts_next = div_us;
            T_OUT: begin
                if (out_free) begin
                    pkt_clear           = 1'b1;
                    mv_next             = 1'b1;
                    out_next.au_start   = stat.flags[0];
                    out_next.au_end     = stat.flags[1];
                    out_next.dts_us     = dts_reg;
                    out_next.pts_us     = pts_reg;
                    out_next.header_bytes = stat.header_bytes;
                end
            end
            default: ;
        endcase
    end

    shp_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .load      (load),
        .word      (s_data),
        .in_ready  (s_ready),
        .pkt_done  (pkt_done),
        .pkt_clear (pkt_clear),
        .stat      (stat)
    );

    shp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .ticks   (div_ticks),
        .res     (cfg_reg.timestamp_resolution),
        .done    (div_done),
        .us      (div_us)
    );

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sl_flags               <= '0;
            cfg_reg.timestamp_resolution   <= RES_W'(1000);
            cfg_reg.timestamp_length       <= LEN_W'(32);
            cfg_reg.ocr_length             <= '0;
            cfg_reg.au_length_bits         <= '0;
            cfg_reg.bitrate_length         <= '0;
            cfg_reg.sequence_field_lengths <= '0;
            st_reg <= T_PARSE;
            mv_reg <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            st_reg  <= st_next;
            mv_reg  <= mv_next;
        end
        dts_reg <= dts_next;
        pts_reg <= pts_next;
        out_reg <= out_next;
    end

endmodule
